// ===== rtl/b64d_pkg.sv =====
package b64d_pkg;

  localparam int LEN_OUT_W = 16;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_PAD   = 8'd61;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_UP_A  = 8'd65;
  localparam logic [7:0] CH_UP_Z  = 8'd90;
  localparam logic [7:0] CH_LO_A  = 8'd97;
  localparam logic [7:0] CH_LO_Z  = 8'd122;
  localparam logic [7:0] CH_DIG_0 = 8'd48;
  localparam logic [7:0] CH_DIG_9 = 8'd57;

  typedef enum logic [1:0] {
    SYM_NONE,
    SYM_DATA,
    SYM_PAD
  } sym_kind_t;

  typedef struct packed {
    logic                 is_end;
    logic [1:0]           nbytes;
    logic [23:0]          data;
    logic [LEN_OUT_W-1:0] len;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

endpackage

// ===== rtl/b64d_front.sv =====
module b64d_front import b64d_pkg::*; #(
  parameter int LENGTH_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       q_full,
  output push_t      q_push
);

  logic [23:0]             acc_r, acc_nxt;
  logic [1:0]              scnt_r, scnt_nxt;
  logic [1:0]              pcnt_r, pcnt_nxt;
  logic                    fin_r, fin_nxt;
  logic [LENGTH_WIDTH-1:0] len_r, len_nxt;

  sym_kind_t               kind;
  logic [5:0]              sx;
  logic                    take;
  logic [1:0]              nbytes;
  logic [LENGTH_WIDTH:0]   len_sum;
  logic [LEN_OUT_W-1:0]    len_rep;

  always_comb begin
    kind = SYM_NONE;
    sx   = 6'd0;
    if (char_in >= CH_UP_A && char_in <= CH_UP_Z) begin
      kind = SYM_DATA;
      sx   = 6'(char_in - CH_UP_A);
    end else if (char_in >= CH_LO_A && char_in <= CH_LO_Z) begin
      kind = SYM_DATA;
      sx   = 6'(char_in - 8'd71);
    end else if (char_in >= CH_DIG_0 && char_in <= CH_DIG_9) begin
      kind = SYM_DATA;
      sx   = 6'(char_in + 8'd4);
    end else if (char_in == CH_PLUS) begin
      kind = SYM_DATA;
      sx   = 6'd62;
    end else if (char_in == CH_SLASH) begin
      kind = SYM_DATA;
      sx   = 6'd63;
    end else if (char_in == CH_PAD) begin
      kind = SYM_PAD;
    end
  end

  generate
    if (LENGTH_WIDTH > LEN_OUT_W) begin : g_sat
      assign len_rep = (|len_r[LENGTH_WIDTH-1:LEN_OUT_W]) ? '1 : len_r[LEN_OUT_W-1:0];
    end else begin : g_ext
      assign len_rep = LEN_OUT_W'(len_r);
    end
  endgenerate

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    if (pcnt_r == 2'd0 && kind != SYM_PAD) begin
      nbytes = 2'd3;
    end else if (pcnt_r == 2'd0 || (pcnt_r == 2'd1 && kind != SYM_PAD)) begin
      nbytes = 2'd2;
    end else begin
      nbytes = 2'd1;
    end
  end

  assign len_sum = {1'b0, len_r} + (LENGTH_WIDTH+1)'(nbytes);

  always_comb begin
    acc_nxt     = acc_r;
    scnt_nxt    = scnt_r;
    pcnt_nxt    = pcnt_r;
    fin_nxt     = fin_r;
    len_nxt     = len_r;
    q_push      = '0;
    if (take) begin
      if (char_in == CH_CR) begin
        q_push.push       = 1'b1;
        q_push.job.is_end = 1'b1;
        q_push.job.nbytes = 2'd1;
        q_push.job.len    = len_rep;
        acc_nxt           = '0;
        scnt_nxt          = '0;
        pcnt_nxt          = '0;
        fin_nxt           = 1'b0;
        len_nxt           = '0;
      end else if (!fin_r && kind != SYM_NONE) begin
        acc_nxt = {acc_r[17:0], sx};
        if (kind == SYM_PAD && pcnt_r != 2'd3) begin
          pcnt_nxt = pcnt_r + 2'd1;
        end
        if (scnt_r != 2'd3) begin
          scnt_nxt = scnt_r + 2'd1;
        end else begin
          scnt_nxt          = '0;
          fin_nxt           = (nbytes != 2'd3);
          len_nxt           = len_sum[LENGTH_WIDTH] ? '1 : len_sum[LENGTH_WIDTH-1:0];
          q_push.push       = 1'b1;
          q_push.job.nbytes = nbytes;
          q_push.job.data   = {acc_r[17:0], sx};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      scnt_r <= '0;
      pcnt_r <= '0;
      fin_r  <= 1'b0;
      len_r  <= '0;
    end else begin
      acc_r  <= acc_nxt;
      scnt_r <= scnt_nxt;
      pcnt_r <= pcnt_nxt;
      fin_r  <= fin_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

// ===== rtl/b64d_queue.sv =====
module b64d_queue import b64d_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t q_push,
  output logic  q_full,
  input  logic  q_pop,
  output logic  q_valid,
  output job_t  q_head
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_pop;

  assign q_full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_head  = mem_r[rd_ptr_r];
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(q_push.push);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(do_pop);
    cnt_nxt    = cnt_r + (QPTR_W+1)'(q_push.push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem_r[wr_ptr_r] <= q_push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/b64d_back.sv =====
module b64d_back import b64d_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  job_t                 q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           byte_out,
  output logic                 is_end,
  output logic [LEN_OUT_W-1:0] decoded_length,
  output logic                 last
);

  logic [1:0] idx_r, idx_nxt;
  logic       fire;

  assign out_valid = q_valid;
  assign fire      = out_valid && out_ready;
  assign last      = (idx_r + 2'd1 == q_head.nbytes);
  assign q_pop     = fire && last;
  assign is_end    = q_head.is_end;

  always_comb begin
    byte_out       = '0;
    decoded_length = '0;
    if (q_head.is_end) begin
      decoded_length = q_head.len;
    end else begin
      case (idx_r)
        2'd0:    byte_out = q_head.data[23:16];
        2'd1:    byte_out = q_head.data[15:8];
        default: byte_out = q_head.data[7:0];
      endcase
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (fire) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// ===== rtl/base64_text_decoder_unit.sv =====
// streaming base64 decoder: one ascii character per in_ transaction, standard
// alphabet, '=' pads, other characters skipped; each complete group of four
// gives three bytes (two or one when padded, after which input is skipped up
// to carriage return), and a carriage return gives an end transaction with the
// decoded byte count (saturating at 65535) before the state clears. a
// character is taken every cycle while the four-entry job queue between the
// classifying front end and the byte emitter has room; the emitter sends one
// result per cycle while out_ready is high.
module base64_text_decoder_unit import b64d_pkg::*; #(
  parameter int LENGTH_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_char_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte_out,
  output logic                 out_is_end,
  output logic [LEN_OUT_W-1:0] out_decoded_length,
  output logic                 out_last
);

  push_t q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  job_t  q_head;

  b64d_front #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .char_in  (in_char_in),
    .q_full   (q_full),
    .q_push   (q_push)
  );

  b64d_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  b64d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .byte_out       (out_byte_out),
    .is_end         (out_is_end),
    .decoded_length (out_decoded_length),
    .last           (out_last)
  );

endmodule

// ===== rtl/b64d_checker.sv =====
module b64d_checker import b64d_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [7:0]           in_char_in,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [7:0]           out_byte_out,
  input logic                 out_is_end,
  input logic [LEN_OUT_W-1:0] out_decoded_length,
  input logic                 out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_out) && $stable(out_is_end)
      && $stable(out_decoded_length) && $stable(out_last))
    else $error("result changed while stalled");

  // end transaction is a single zero-byte last result
  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_end |-> out_last && out_byte_out == 8'd0)
    else $error("bad end transaction");

  // byte transactions carry no length
  a_byte_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_end |-> out_decoded_length == '0)
    else $error("length on byte transaction");

  // nothing to send right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind base64_text_decoder_unit b64d_checker u_chk (.*);
